FILE: rtl/biquad_df2t_filter_top_defines.svh
// Assertion macros for the biquad filter RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BIQUAD_DF2T_FILTER_TOP_DEFINES_SVH
`define BIQUAD_DF2T_FILTER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define BQD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define BQD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define BQD_ASSERT(lbl, clk, rst_n, prop, msg)
`define BQD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

FILE: rtl/bqd_pkg.sv
// Shared constants and types for the biquad filter.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package bqd_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int COEF_FRAC_BITS  = 28;
    localparam int COEF_BITS       = 32;
    localparam int STATE_BITS      = 48;
    localparam int PROD_SHIFT      = 12;
    localparam int STATE_FRAC_BITS = COEF_FRAC_BITS - PROD_SHIFT;
    localparam int PROD_BITS       = COEF_BITS + SAMPLE_BITS;
    localparam int SCALED_BITS     = PROD_BITS - PROD_SHIFT;
    localparam int ACC_BITS        = ((SCALED_BITS > STATE_BITS) ? SCALED_BITS : STATE_BITS) + 2;
    localparam int ROUND_BITS      = ACC_BITS - STATE_FRAC_BITS;
    localparam int NUM_COEFS       = 5;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_BITS-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        COEF_B0 = CFG_INDEX_BITS'(0),
        COEF_B1 = CFG_INDEX_BITS'(1),
        COEF_B2 = CFG_INDEX_BITS'(2),
        COEF_A1 = CFG_INDEX_BITS'(3),
        COEF_A2 = CFG_INDEX_BITS'(4)
    } t_coef_idx;

    typedef struct packed {
        logic      en;
        t_coef_idx sel;
        logic      use_y;
    } t_mac_cmd;

endpackage

`default_nettype wire

FILE: rtl/bqd_coef_regs.sv
// Coefficient register file with write port and one selected read.
// Depends on bqd_pkg.
`default_nettype none

module bqd_coef_regs (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [bqd_pkg::CFG_INDEX_BITS-1:0]    i_cfg_index,
    input  wire logic [bqd_pkg::COEF_BITS-1:0]         i_cfg_data,
    input  wire bqd_pkg::t_coef_idx                    i_sel,
    output logic [bqd_pkg::COEF_BITS-1:0]              o_coef
);

    logic [bqd_pkg::COEF_BITS-1:0] r_coef [bqd_pkg::NUM_COEFS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= bqd_pkg::COEF_ONE;
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bqd_pkg::COEF_B0: r_coef[0] <= i_cfg_data;
                bqd_pkg::COEF_B1: r_coef[1] <= i_cfg_data;
                bqd_pkg::COEF_B2: r_coef[2] <= i_cfg_data;
                bqd_pkg::COEF_A1: r_coef[3] <= i_cfg_data;
                bqd_pkg::COEF_A2: r_coef[4] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_sel)
            bqd_pkg::COEF_B0: o_coef = r_coef[0];
            bqd_pkg::COEF_B1: o_coef = r_coef[1];
            bqd_pkg::COEF_B2: o_coef = r_coef[2];
            bqd_pkg::COEF_A1: o_coef = r_coef[3];
            bqd_pkg::COEF_A2: o_coef = r_coef[4];
            default:          o_coef = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/bqd_mac.sv
// Shared signed multiplier with registered product.
// Depends on bqd_pkg.
`default_nettype none

module bqd_mac (
    input  wire logic                                i_clk,
    input  wire bqd_pkg::t_mac_cmd                   i_cmd,
    input  wire logic [bqd_pkg::COEF_BITS-1:0]       i_coef,
    input  wire logic [bqd_pkg::SAMPLE_BITS-1:0]     i_x,
    input  wire logic [bqd_pkg::SAMPLE_BITS-1:0]     i_y,
    output logic signed [bqd_pkg::PROD_BITS-1:0]     o_prod
);

    logic [bqd_pkg::SAMPLE_BITS-1:0] w_op;
    logic signed [bqd_pkg::PROD_BITS-1:0] r_prod;

    assign w_op   = i_cmd.use_y ? i_y : i_x;
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        if (i_cmd.en) begin
            r_prod <= $signed(i_coef) * $signed(w_op);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/biquad_df2t_filter_top.sv
// Biquad IIR section, transposed direct form II, on one shared multiplier.
// Depends on bqd_pkg, bqd_coef_regs, bqd_mac and the assertion macro header.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry i_sample_in and i_clear.
//   Output channel: o_out_valid / i_out_stall carry o_sample_out, o_saturated.
//   Config channel: i_cfg_valid / o_cfg_ready write coefficient i_cfg_index
//   (b0, b1, b2, a1, a2) with i_cfg_data; write only while the filter is idle.
//   Each sample runs eight steps on the single multiplier and accumulator,
//   and its word is loaded into the output register in the last step; the
//   block accepts a new sample only in that last step or while idle.
//   The input is taken again in the last step, so back-to-back samples
//   stream with no idle step between them while the output is not stalled.
//   If the receiver stalls, the finished word holds in the output register
//   and the next sample is still accepted; its last step waits until the
//   output register is free.
//   Reset loads pass-through coefficients (b0 = 1.0) and clears both delay
//   states and the output valid.
`default_nettype none
`include "biquad_df2t_filter_top_defines.svh"

module biquad_df2t_filter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [bqd_pkg::SAMPLE_BITS-1:0]     i_sample_in,
    input  wire logic                                i_clear,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic [bqd_pkg::SAMPLE_BITS-1:0]          o_sample_out,
    output logic                                     o_saturated,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [bqd_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire logic [bqd_pkg::COEF_BITS-1:0]       i_cfg_data
);

    localparam int SB  = bqd_pkg::SAMPLE_BITS;
    localparam int AB  = bqd_pkg::ACC_BITS;
    localparam int STB = bqd_pkg::STATE_BITS;
    localparam int RB  = bqd_pkg::ROUND_BITS;
    localparam int SF  = bqd_pkg::STATE_FRAC_BITS;
    localparam int PB  = bqd_pkg::PROD_BITS;
    localparam int PS  = bqd_pkg::PROD_SHIFT;
    localparam int SCB = bqd_pkg::SCALED_BITS;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MUL_B0   = 9'b000000010,
        S_ACC_D1   = 9'b000000100,
        S_ROUND_Y  = 9'b000001000,
        S_ACC_D2   = 9'b000010000,
        S_SUB_A1   = 9'b000100000,
        S_STORE_D1 = 9'b001000000,
        S_SUB_A2   = 9'b010000000,
        S_STORE_D2 = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [SB-1:0]  r_x, r_y, r_sample_out;
    logic [AB-1:0]  r_acc;
    logic [STB-1:0] r_d1, r_d2;
    logic           r_sat, n_sat, r_saturated, r_out_valid, n_out_valid;

    bqd_pkg::t_mac_cmd              w_cmd;
    logic [bqd_pkg::COEF_BITS-1:0]  w_coef;
    logic signed [PB-1:0]           w_prod;

    logic          w_in_ready, w_accept;
    logic          w_sub, w_acc_load, w_y_load, w_d1_load, w_out_load;
    logic [AB-1:0] w_add_a, w_sc_ext, w_sum;
    logic          w_cin;
    logic [RB-1:0] w_yr;
    logic          w_y_clip, w_st_clip;
    logic [SB-1:0] w_y_sat;
    logic [STB-1:0] w_st_sat;

    bqd_coef_regs u_coef_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sel       (w_cmd.sel),
        .o_coef      (w_coef)
    );

    bqd_mac u_mac (
        .i_clk  (i_clk),
        .i_cmd  (w_cmd),
        .i_coef (w_coef),
        .i_x    (r_x),
        .i_y    (r_y),
        .o_prod (w_prod)
    );

    always_comb begin
        n_state    = r_state;
        w_in_ready = 1'b0;
        w_cmd.en   = 1'b0;
        w_cmd.sel  = bqd_pkg::COEF_B0;
        w_cmd.use_y = 1'b0;
        w_add_a    = r_acc;
        w_sub      = 1'b0;
        w_acc_load = 1'b0;
        w_y_load   = 1'b0;
        w_d1_load  = 1'b0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = S_MUL_B0;
                end
            end
            S_MUL_B0: begin
                w_cmd.en  = 1'b1;
                w_cmd.sel = bqd_pkg::COEF_B0;
                n_state   = S_ACC_D1;
            end
            S_ACC_D1: begin
                w_add_a    = {{(AB-STB){r_d1[STB-1]}}, r_d1};
                w_acc_load = 1'b1;
                n_state    = S_ROUND_Y;
            end
            S_ROUND_Y: begin
                w_y_load  = 1'b1;
                w_cmd.en  = 1'b1;
                w_cmd.sel = bqd_pkg::COEF_B1;
                n_state   = S_ACC_D2;
            end
            S_ACC_D2: begin
                w_add_a     = {{(AB-STB){r_d2[STB-1]}}, r_d2};
                w_acc_load  = 1'b1;
                w_cmd.en    = 1'b1;
                w_cmd.sel   = bqd_pkg::COEF_A1;
                w_cmd.use_y = 1'b1;
                n_state     = S_SUB_A1;
            end
            S_SUB_A1: begin
                w_sub      = 1'b1;
                w_acc_load = 1'b1;
                w_cmd.en   = 1'b1;
                w_cmd.sel  = bqd_pkg::COEF_B2;
                n_state    = S_STORE_D1;
            end
            S_STORE_D1: begin
                w_d1_load   = 1'b1;
                w_add_a     = '0;
                w_acc_load  = 1'b1;
                w_cmd.en    = 1'b1;
                w_cmd.sel   = bqd_pkg::COEF_A2;
                w_cmd.use_y = 1'b1;
                n_state     = S_SUB_A2;
            end
            S_SUB_A2: begin
                w_sub      = 1'b1;
                w_acc_load = 1'b1;
                n_state    = S_STORE_D2;
            end
            S_STORE_D2: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    w_in_ready = 1'b1;
                    n_state    = i_in_valid ? S_MUL_B0 : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_accept   = i_in_valid && w_in_ready;
    assign o_in_stall = !w_in_ready;

    // rounded product: floor(p / 2^PS) plus bit PS-1, folded into the carry-in
    assign w_sc_ext = {{(AB-SCB){w_prod[PB-1]}}, w_prod[PB-1:PS]};
    assign w_cin    = w_sub ? !w_prod[PS-1] : w_prod[PS-1];
    assign w_sum    = w_add_a + (w_sub ? ~w_sc_ext : w_sc_ext) + {{(AB-1){1'b0}}, w_cin};

    assign w_yr     = r_acc[AB-1:SF] + {{(RB-1){1'b0}}, r_acc[SF-1]};
    assign w_y_clip = !((&w_yr[RB-1:SB-1]) || !(|w_yr[RB-1:SB-1]));
    assign w_y_sat  = w_y_clip ? {w_yr[RB-1], {(SB-1){!w_yr[RB-1]}}} : w_yr[SB-1:0];

    assign w_st_clip = !((&r_acc[AB-1:STB-1]) || !(|r_acc[AB-1:STB-1]));
    assign w_st_sat  = w_st_clip ? {r_acc[AB-1], {(STB-1){!r_acc[AB-1]}}} : r_acc[STB-1:0];

    always_comb begin
        n_sat = r_sat;
        if (w_y_load) begin
            n_sat = r_sat | w_y_clip;
        end
        if (w_d1_load) begin
            n_sat = r_sat | w_st_clip;
        end
        if (w_accept) begin
            n_sat = 1'b0;
        end
    end

    assign n_out_valid = w_out_load || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_d1        <= '0;
            r_d2        <= '0;
        end else begin
            r_state     <= n_state;
            r_sat       <= n_sat;
            r_out_valid <= n_out_valid;
            if (w_accept && i_clear) begin
                r_d1 <= '0;
                r_d2 <= '0;
            end else begin
                if (w_d1_load) begin
                    r_d1 <= w_st_sat;
                end
                if (w_out_load) begin
                    r_d2 <= w_st_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x <= i_sample_in;
        end
        if (w_acc_load) begin
            r_acc <= w_sum;
        end
        if (w_y_load) begin
            r_y <= w_y_sat;
        end
        if (w_out_load) begin
            r_sample_out <= r_y;
            r_saturated  <= r_sat | w_st_clip;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_sample_out;
    assign o_saturated  = r_saturated;

    `BQD_ASSERT(a_accept_starts, i_clk, i_rst_n, w_accept |=> (r_state == S_MUL_B0), "accepted sample did not start the multiply sequence")
    `BQD_ASSERT(a_clear_zeroes, i_clk, i_rst_n, (w_accept && i_clear) |=> (r_d1 == '0 && r_d2 == '0), "clear did not zero the delay states")
    `BQD_ASSERT(a_out_from_store, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_STORE_D2), "output word appeared outside the final step")
    `BQD_ASSERT_NEVER(a_no_mid_accept, i_clk, i_rst_n, w_accept && r_state != S_IDLE && r_state != S_STORE_D2, "sample accepted in the middle of a sequence")

endmodule

`default_nettype wire

FILE: verif/tb_biquad_df2t_filter_top.sv
// Self-checking testbench for biquad_df2t_filter_top: directed and random samples
// against a bit-exact fixed-point filter predictor, with random idling on both sides.
// Depends on bqd_pkg and the biquad_df2t_filter_top RTL.
`default_nettype none

module tb_biquad_df2t_filter_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SBITS        = bqd_pkg::SAMPLE_BITS;
    localparam int CBITS        = bqd_pkg::COEF_BITS;
    localparam int IBITS        = bqd_pkg::CFG_INDEX_BITS;
    localparam int CLK_PERIOD   = 4;
    localparam int LATENCY      = 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 26;
    localparam int STABLE_POLE  = 241591910;
    localparam int PHASE_WORDS  = 200;
    localparam int NUM_PHASES   = 7;

    typedef struct packed {
        logic [SBITS-1:0] sample;
        logic             sat;
    } t_filt_word;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [SBITS-1:0]     i_sample_in = '0;
    logic                 i_clear = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [SBITS-1:0]     o_sample_out;
    logic                 o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [IBITS-1:0]     i_cfg_index = '0;
    logic [CBITS-1:0]     i_cfg_data = '0;

    logic signed [CBITS-1:0] coef_reg [bqd_pkg::NUM_COEFS];
    longint                  dly_one;
    longint                  dly_two;
    t_filt_word              pending_words [$];
    t_filt_word              want;
    int                      errors = 0;
    int                      cycles = 0;
    bit                      steady = 1'b0;

    biquad_df2t_filter_top u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_in  (i_sample_in),
        .i_clear      (i_clear),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_sample_out (o_sample_out),
        .o_saturated  (o_saturated),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_biquad_df2t_filter_top failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end

    function automatic longint scale_product(logic signed [CBITS-1:0] c, longint v);
        longint p;
        p = longint'(c) * v;
        return (p + (longint'(1) <<< (bqd_pkg::PROD_SHIFT - 1))) >>> bqd_pkg::PROD_SHIFT;
    endfunction

    function automatic longint clip(longint v, int w, inout bit hit);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo) begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic t_filt_word filter_sample(logic [SBITS-1:0] x_bits, logic clr);
        longint     x;
        longint     acc;
        longint     y;
        longint     n1;
        longint     n2;
        bit         hit;
        t_filt_word w;
        x = longint'($signed(x_bits));
        hit = 1'b0;
        if (clr) begin
            dly_one = 0;
            dly_two = 0;
        end
        acc = scale_product(coef_reg[bqd_pkg::COEF_B0], x) + dly_one;
        y = clip((acc + (longint'(1) <<< (bqd_pkg::STATE_FRAC_BITS - 1)))
                 >>> bqd_pkg::STATE_FRAC_BITS, SBITS, hit);
        n1 = scale_product(coef_reg[bqd_pkg::COEF_B1], x)
             - scale_product(coef_reg[bqd_pkg::COEF_A1], y) + dly_two;
        n2 = scale_product(coef_reg[bqd_pkg::COEF_B2], x)
             - scale_product(coef_reg[bqd_pkg::COEF_A2], y);
        dly_one = clip(n1, bqd_pkg::STATE_BITS, hit);
        dly_two = clip(n2, bqd_pkg::STATE_BITS, hit);
        w.sample = y[SBITS-1:0];
        w.sat = hit;
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        errors++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h sat %b", o_sample_out,
                                          o_saturated));
            end else begin
                want = pending_words.pop_front();
                if (o_sample_out !== want.sample) begin
                    report_mismatch($sformatf("sample_out %h, want %h", o_sample_out,
                                              want.sample));
                end
                if (o_saturated !== want.sat) begin
                    report_mismatch($sformatf("saturated %b, want %b", o_saturated, want.sat));
                end
            end
        end
    end

    task automatic send_sample(input logic [SBITS-1:0] x, input logic clr);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= x;
        i_clear     <= clr;
        do @(posedge i_clk); while (o_in_stall);
        pending_words.push_back(filter_sample(x, clr));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_coef(input logic [IBITS-1:0] idx, input logic [CBITS-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx < bqd_pkg::NUM_COEFS) begin
            coef_reg[idx] = value;
        end
        @(posedge i_clk);
    endtask

    task automatic load_filter(input logic [CBITS-1:0] b0, input logic [CBITS-1:0] b1,
                               input logic [CBITS-1:0] b2, input logic [CBITS-1:0] a1,
                               input logic [CBITS-1:0] a2);
        wait_drained();
        write_coef(bqd_pkg::COEF_B0, b0);
        write_coef(bqd_pkg::COEF_B1, b1);
        write_coef(bqd_pkg::COEF_B2, b2);
        write_coef(bqd_pkg::COEF_A1, a1);
        write_coef(bqd_pkg::COEF_A2, a2);
    endtask

    task automatic test_passthrough();
        send_sample(24'h000000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        send_sample(24'h800000, 1'b1);
        send_sample(24'hFFFFFF, 1'b0);
        send_sample(24'h000001, 1'b1);
        send_sample(24'h555555, 1'b0);
        send_sample(24'hAAAAAA, 1'b0);
    endtask

    task automatic test_coef_extremes();
        load_filter(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
        send_sample(24'h7FFFFF, 1'b1);
        send_sample(24'h800000, 1'b0);
        send_sample(24'h7FFFFF, 1'b0);
        wait_drained();
        for (int k = 0; k < (1 << IBITS) - bqd_pkg::NUM_COEFS; k++) begin
            write_coef(IBITS'(bqd_pkg::NUM_COEFS + k), $urandom());
        end
        send_sample(24'h800000, 1'b1);
        send_sample(24'h000000, 1'b0);
    endtask

    task automatic test_unstable_poles();
        load_filter(bqd_pkg::COEF_ONE, 32'h00000000, 32'h00000000, 32'hC0000000,
                    32'h30000000);
        send_sample(24'h100000, 1'b1);
        for (int n = 0; n < 8; n++) begin
            send_sample(24'h000000, 1'b0);
        end
        send_sample(24'h000010, 1'b1);
    endtask

    task automatic test_random_filters();
        longint a1;
        longint a2;
        longint lim;
        longint one;
        longint ff [3];
        logic [SBITS-1:0] x;
        one = longint'(bqd_pkg::COEF_ONE);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 3)
                0: begin
                    load_filter($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
                end
                1: begin
                    a2 = longint'($urandom_range(0, 2 * STABLE_POLE)) - STABLE_POLE;
                    lim = ((one + a2) * 9) / 10;
                    a1 = longint'($urandom_range(0, 32'(2 * lim))) - lim;
                    for (int k = 0; k < 3; k++) begin
                        ff[k] = longint'($urandom_range(0, 32'(2 * one))) - one;
                    end
                    load_filter(CBITS'(ff[0]), CBITS'(ff[1]), CBITS'(ff[2]),
                                CBITS'(a1), CBITS'(a2));
                end
                default: begin
                    load_filter($urandom_range(0, 32'h3FFFFFFF) - 32'h20000000,
                                $urandom_range(0, 32'h3FFFFFFF) - 32'h20000000,
                                $urandom_range(0, 32'h3FFFFFFF) - 32'h20000000,
                                $urandom_range(0, 32'h3FFFFFFF) - 32'h20000000,
                                $urandom_range(0, 32'h3FFFFFFF) - 32'h20000000);
                end
            endcase
            steady = (ph == 3);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    x = SBITS'($urandom_range(0, 8191) - 4096);
                end else begin
                    x = SBITS'($urandom());
                end
                send_sample(x, $urandom_range(0, 99) < 3);
                if (ph == 2 && n == PHASE_WORDS / 2) begin
                    wait_drained();
                end
            end
            steady = 1'b0;
        end
    endtask

    initial begin
        coef_reg[bqd_pkg::COEF_B0] = bqd_pkg::COEF_ONE;
        coef_reg[bqd_pkg::COEF_B1] = '0;
        coef_reg[bqd_pkg::COEF_B2] = '0;
        coef_reg[bqd_pkg::COEF_A1] = '0;
        coef_reg[bqd_pkg::COEF_A2] = '0;
        dly_one = 0;
        dly_two = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough();
        test_coef_extremes();
        test_unstable_poles();
        test_random_filters();
        wait_drained();
        if (errors == 0) begin
            $display("tb_biquad_df2t_filter_top passed");
        end else begin
            $display("tb_biquad_df2t_filter_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
